// ===== rtl/pcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// pcbp_pkg
// Shared types and constants of the prefix-code bit packer: request
// structs, opcodes, queue item layout and default parameter values.
// ----------------------------------------------------------------------------
package pcbp_pkg;

  localparam int unsigned SymW          = 8;
  localparam int unsigned CodeW         = 32;
  localparam int unsigned LenW          = 6;
  localparam int unsigned TableDepth    = 256;
  localparam int unsigned LenFieldMax   = 63;
  localparam int unsigned MaxCodeLenDef = 32;
  localparam int unsigned QueueDepthDef = 4;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // kind of work handed from the front end to the back end
  typedef enum logic [1:0] {
    ITEM_ENCODE  = 2'd0,
    ITEM_FINISH  = 2'd1,
    ITEM_MISSING = 2'd2
  } item_kind_e;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [SymW-1:0] symbol;
    logic [CodeW-1:0] code_word;
    logic [LenW-1:0] code_length;
  } in_req_t;

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       byte_valid;
    logic       is_last;
    logic [2:0] padding_count;
    logic       symbol_missing;
  } out_req_t;

  typedef struct packed {
    item_kind_e       kind;
    logic [LenW-1:0]  len;
    logic [CodeW-1:0] code;
  } q_item_t;

endpackage

// ===== rtl/prefix_code_bit_packer_core.sv =====
// ----------------------------------------------------------------------------
// prefix_code_bit_packer_core
// Table-driven prefix-code encoder: loads code table entries, packs codes
// of encoded symbols into bytes and flushes the last byte on finish.
// ----------------------------------------------------------------------------
// a finish or missing-symbol result passes the lookup stage, the queue and the
//   output register; the first byte of an encode also passes the aligner
// one request per cycle into the front end unless the queue is full; the aligner
//   takes an encode, emits its bytes as the output frees, then keeps leftover bits
// reset: control clears at once; the length table is marked empty by per-entry
//   valid bits, so no clearing pass is needed; the code table is not reset
module prefix_code_bit_packer_core import pcbp_pkg::*; #(
  parameter int unsigned MAX_CODE_LEN = MaxCodeLenDef,
  parameter int unsigned QUEUE_DEPTH  = QueueDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  // request side
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  // result side
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  // front end to queue
  logic    push;
  q_item_t push_item;
  logic    q_full;

  // queue to back end
  logic    q_valid;
  q_item_t q_item;
  logic    q_pop;

  // front end: table writes, symbol lookup and classification
  pcbp_front #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .push_o     (push),
    .item_o     (push_item),
    .full_i     (q_full)
  );

  // decouples lookup from byte packing so either side can stall alone
  pcbp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // back end: bit aligner and output register
  pcbp_back #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

// ===== rtl/pcbp_ram.sv =====
// ----------------------------------------------------------------------------
// pcbp_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module pcbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pcbp_front.sv =====
// ----------------------------------------------------------------------------
// pcbp_front
// Accepts requests, writes table loads, looks up encode symbols and
// classifies each encode or finish into a queue item.
// ----------------------------------------------------------------------------
module pcbp_front import pcbp_pkg::*; #(
  parameter int unsigned MAX_CODE_LEN = MaxCodeLenDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  in_req_t in_req_i,
  output logic    push_o,
  output q_item_t item_o,
  input  logic    full_i
);

  localparam int unsigned LenMax = (MAX_CODE_LEN > LenFieldMax) ? LenFieldMax : MAX_CODE_LEN;

  logic                  accept;
  logic                  is_load;
  logic                  is_work;
  logic [LenW-1:0]       len_clamped;
  logic [CodeW-1:0]      word_masked;
  logic [CodeW-1:0]      code_rd;
  logic [LenW-1:0]       len_rd;
  logic [TableDepth-1:0] entry_vld_q;
  logic                  s1_valid_q, s1_valid_d;
  item_kind_e            s1_kind_q;
  logic                  s1_hit_q;

  assign accept  = in_valid_i && !in_stall_o;
  assign is_load = (in_req_i.opcode == OP_LOAD);
  assign is_work = (in_req_i.opcode == OP_ENCODE) || (in_req_i.opcode == OP_FINISH);

  // saturate the length and keep only the low code bits
  assign len_clamped = (in_req_i.code_length > LenW'(LenMax)) ? LenW'(LenMax)
                                                             : in_req_i.code_length;
  assign word_masked = in_req_i.code_word & ~({CodeW{1'b1}} << len_clamped);

  pcbp_ram #(.WIDTH(CodeW), .DEPTH(TableDepth)) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (accept && is_load),
    .waddr_i (in_req_i.symbol),
    .wdata_i (word_masked),
    .re_i    (accept),
    .raddr_i (in_req_i.symbol),
    .rdata_o (code_rd)
  );

  pcbp_ram #(.WIDTH(LenW), .DEPTH(TableDepth)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (accept && is_load),
    .waddr_i (in_req_i.symbol),
    .wdata_i (len_clamped),
    .re_i    (accept),
    .raddr_i (in_req_i.symbol),
    .rdata_o (len_rd)
  );

  // lookup stage drains into the queue unless it is full
  assign push_o     = s1_valid_q && !full_i;
  assign in_stall_o = s1_valid_q && full_i;
  assign s1_valid_d = (!s1_valid_q || push_o) ? (accept && is_work) : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= '0;
      s1_valid_q  <= 1'b0;
      s1_kind_q   <= ITEM_ENCODE;
      s1_hit_q    <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept && is_load) begin
        entry_vld_q[in_req_i.symbol] <= 1'b1;
      end
      if (accept) begin
        s1_kind_q <= (in_req_i.opcode == OP_FINISH) ? ITEM_FINISH : ITEM_ENCODE;
        s1_hit_q  <= entry_vld_q[in_req_i.symbol];
      end
    end
  end

  always_comb begin
    item_o.len  = len_rd;
    item_o.code = code_rd;
    if (s1_kind_q == ITEM_FINISH) begin
      item_o.kind = ITEM_FINISH;
    end else if (!s1_hit_q || (len_rd == '0)) begin
      item_o.kind = ITEM_MISSING;
    end else begin
      item_o.kind = ITEM_ENCODE;
    end
  end

`ifndef ASSERT_OFF
  // new request only when the lookup stage is free or moving on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (!s1_valid_q || push_o))
    else $error("pcbp_front: lookup stage overwritten");
`endif

endmodule

// ===== rtl/pcbp_queue.sv =====
// ----------------------------------------------------------------------------
// pcbp_queue
// Small register queue of classified items between front and back end.
// ----------------------------------------------------------------------------
module pcbp_queue import pcbp_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t item_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output q_item_t item_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  q_item_t         mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("pcbp_queue: push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pcbp_queue: pop from empty queue");
`endif

endmodule

// ===== rtl/pcbp_back.sv =====
// ----------------------------------------------------------------------------
// pcbp_back
// Bit aligner: merges code bits into the held partial byte, one output byte
// per cycle while the output is free, and drives the result register.
// ----------------------------------------------------------------------------
module pcbp_back import pcbp_pkg::*; #(
  parameter int unsigned MAX_CODE_LEN = MaxCodeLenDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  q_item_t  q_item_i,
  output logic     q_pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  localparam int unsigned LenMax = (MAX_CODE_LEN > LenFieldMax) ? LenFieldMax : MAX_CODE_LEN;
  localparam int unsigned RemW   = $clog2(LenMax + 1);

  logic              busy_q, busy_d;
  logic [LenMax-1:0] aligned_q, aligned_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [7:0]        pa_q, pa_d;
  logic [2:0]        cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  out_req_t          out_q, out_d;

  logic              out_free;
  logic              emit;
  out_req_t          result;
  logic [3:0]        take;
  logic [7:0]        merged;
  logic              full_byte;
  logic [6:0]        shamt;
  logic [63:0]       code_shifted;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign take      = 4'd8 - {1'b0, cnt_q};
  assign merged    = pa_q | (aligned_q[LenMax-1 -: 8] >> cnt_q);
  assign full_byte = (7'(rem_q) + 7'(cnt_q)) >= 7'd8;
  // left-align the new code in the aligner window
  assign shamt        = 7'(LenMax) - 7'(q_item_i.len);
  assign code_shifted = 64'(q_item_i.code) << shamt;

  always_comb begin
    busy_d    = busy_q;
    aligned_d = aligned_q;
    rem_d     = rem_q;
    pa_d      = pa_q;
    cnt_d     = cnt_q;
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    result    = '0;
    if (busy_q) begin
      if (!full_byte) begin
        // remaining bits fit in the partial byte
        pa_d   = merged;
        cnt_d  = cnt_q + 3'(rem_q);
        rem_d  = '0;
        busy_d = 1'b0;
      end else if (out_free) begin
        emit              = 1'b1;
        result.packed_byte = merged;
        result.byte_valid  = 1'b1;
        aligned_d = aligned_q << take;
        rem_d     = rem_q - RemW'(take);
        pa_d      = '0;
        cnt_d     = '0;
        busy_d    = (rem_q != RemW'(take));
      end
    end else if (q_valid_i) begin
      case (q_item_i.kind)
        ITEM_ENCODE: begin
          q_pop_o   = 1'b1;
          busy_d    = 1'b1;
          rem_d     = RemW'(q_item_i.len);
          aligned_d = code_shifted[LenMax-1:0];
        end
        ITEM_FINISH: begin
          if (out_free) begin
            q_pop_o        = 1'b1;
            emit           = 1'b1;
            result.is_last = 1'b1;
            if (cnt_q != '0) begin
              result.packed_byte   = pa_q;
              result.byte_valid    = 1'b1;
              result.padding_count = 3'(take);
            end
            pa_d  = '0;
            cnt_d = '0;
          end
        end
        ITEM_MISSING: begin
          if (out_free) begin
            q_pop_o               = 1'b1;
            emit                  = 1'b1;
            result.symbol_missing = 1'b1;
          end
        end
        default: begin
          q_pop_o = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_d       = result;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rem_q       <= '0;
      pa_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      rem_q       <= rem_d;
      pa_q        <= pa_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    aligned_q <= aligned_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q != '0))
    else $error("pcbp_back: active encode with no bits left");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pa_q & (8'hFF >> cnt_q)) == 8'h00)
    else $error("pcbp_back: stray bits below held count");
`endif

endmodule

// ===== verif/prefix_code_bit_packer_core_tb.sv =====
// ----------------------------------------------------------------------------
// prefix_code_bit_packer_core_tb
// Self-checking bench for the prefix-code bit packer. A queue of requests
// (table loads, encodes, finishes and unused opcodes) is filled phase by
// phase and fed to the block under random sender gaps and receiver stalls.
// A predictor with its own code table and bit accumulator computes the
// bytes each accepted request should produce; every result leaving the
// block is compared field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module prefix_code_bit_packer_core_tb;
  import pcbp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CodeLimit = MaxCodeLenDef;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req = '0;
  logic     out_valid_o;
  logic     out_stall = 1'b0;
  out_req_t out_req_o;

  prefix_code_bit_packer_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_req_o  (out_req_o)
  );

  always #2 clk_i = ~clk_i;

  // requests waiting to be driven, bytes waiting to come out
  in_req_t  req_fifo[$];
  out_req_t byte_exp_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_count = 0;

  // predictor state
  logic [CodeW-1:0] code_tab[TableDepth];
  logic [LenW-1:0]  len_tab[TableDepth];
  logic [7:0]       acc_bits = '0;
  int unsigned      acc_cnt = 0;

  // generator shadow of which symbols hold a code
  bit               gen_present[TableDepth];
  int unsigned      gen_count = 0;

  initial begin
    foreach (len_tab[i]) len_tab[i] = '0;
    foreach (gen_present[i]) gen_present[i] = 1'b0;
  end

  function automatic out_req_t mk_result(logic [7:0] b, logic v, logic l, logic [2:0] p,
                                         logic m);
    out_req_t r;
    r.packed_byte    = b;
    r.byte_valid     = v;
    r.is_last        = l;
    r.padding_count  = p;
    r.symbol_missing = m;
    return r;
  endfunction

  // append one expected result behind the others
  task automatic exp_add(out_req_t r);
    byte_exp_q.insert(byte_exp_q.size(), r);
  endtask

  // expected bytes of one accepted request
  task automatic pack_predict(in_req_t r);
    logic [LenW-1:0]  len;
    logic [CodeW-1:0] word;
    int unsigned      pad;
    case (op_e'(r.opcode))
      OP_LOAD: begin
        len  = (r.code_length > CodeLimit) ? LenW'(CodeLimit) : r.code_length;
        word = r.code_word;
        if (len < 32) word &= (32'd1 << len) - 32'd1;
        len_tab[r.symbol]  = len;
        code_tab[r.symbol] = word;
      end
      OP_ENCODE: begin
        len  = len_tab[r.symbol];
        word = code_tab[r.symbol];
        if (len == 0) begin
          exp_add(mk_result(8'h00, 1'b0, 1'b0, 3'd0, 1'b1));
        end else begin
          for (int i = int'(len); i > 0; i--) begin
            acc_bits = {acc_bits[6:0], word[i-1]};
            acc_cnt++;
            if (acc_cnt == 8) begin
              exp_add(mk_result(acc_bits, 1'b1, 1'b0, 3'd0, 1'b0));
              acc_bits = '0;
              acc_cnt  = 0;
            end
          end
        end
      end
      OP_FINISH: begin
        if (acc_cnt == 0) begin
          exp_add(mk_result(8'h00, 1'b0, 1'b1, 3'd0, 1'b0));
        end else begin
          pad = 8 - acc_cnt;
          exp_add(mk_result(acc_bits << pad, 1'b1, 1'b1, 3'(pad), 1'b0));
        end
        acc_bits = '0;
        acc_cnt  = 0;
      end
      default: ;
    endcase
  endtask

  // driver: a stalled request holds, otherwise the next one may go out
  always @(posedge clk_i) begin
    logic hold;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      hold = in_valid && in_stall_o;
      if (in_valid && !in_stall_o) pack_predict(in_req);
      if (!hold) begin
        if (req_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_req   <= req_fifo.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    out_req_t exp_r;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (byte_exp_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_req_o);
          err_count++;
        end else begin
          exp_r = byte_exp_q.pop_front();
          check_field("packed_byte", exp_r.packed_byte, out_req_o.packed_byte);
          check_field("byte_valid", 8'(exp_r.byte_valid), 8'(out_req_o.byte_valid));
          check_field("is_last", 8'(exp_r.is_last), 8'(out_req_o.is_last));
          check_field("padding_count", 8'(exp_r.padding_count), 8'(out_req_o.padding_count));
          check_field("symbol_missing", 8'(exp_r.symbol_missing),
                      8'(out_req_o.symbol_missing));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // request builders
  task automatic push_req(op_e op, int unsigned sym, logic [CodeW-1:0] word,
                          logic [LenW-1:0] len);
    in_req_t r;
    r.opcode      = op;
    r.symbol      = SymW'(sym);
    r.code_word   = word;
    r.code_length = len;
    req_fifo.insert(req_fifo.size(), r);
    if (op != OP_NONE) gen_count++;
  endtask

  task automatic add_load(int unsigned sym, logic [CodeW-1:0] word, logic [LenW-1:0] len);
    gen_present[sym] = (len != 0);
    push_req(OP_LOAD, sym, word, len);
  endtask

  task automatic add_encode(int unsigned sym);
    push_req(OP_ENCODE, sym, $urandom, LenW'($urandom));
  endtask

  task automatic add_finish();
    push_req(OP_FINISH, $urandom_range(255), $urandom, LenW'($urandom));
  endtask

  // mostly short codes, some long, a few over the limit
  function automatic logic [LenW-1:0] rand_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 60) return LenW'($urandom_range(1, 8));
    if (p < 85) return LenW'($urandom_range(9, 20));
    if (p < 95) return LenW'($urandom_range(21, 32));
    return LenW'($urandom_range(33, 63));
  endfunction

  // a symbol that holds a code, loading one if the table is empty
  task automatic pick_live(output int unsigned sym);
    int unsigned s;
    s = $urandom_range(255);
    repeat (TableDepth) begin
      if (gen_present[s]) begin
        sym = s;
        return;
      end
      s = (s + 1) % TableDepth;
    end
    sym = $urandom_range(255);
    add_load(sym, $urandom, rand_len());
  endtask

  task automatic wait_idle();
    while (req_fifo.size() != 0 || in_valid || byte_exp_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase_end;
    int unsigned sym;
    int unsigned p;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, masking, saturation, missing, empty finish, padding
    add_load(0, 32'hFFFF_FFFF, 6'd1);
    add_load(255, 32'hFFFF_FFFF, 6'd32);
    add_load(8'h80, 32'hA5A5_A5A5, 6'd63);
    add_load(3, 32'hFFFF_FFEA, 6'd5);
    add_load(9, 32'h0000_0000, 6'd8);
    add_load(7, 32'h1234_5678, 6'd0);
    add_encode(7);
    add_finish();
    add_encode(0);
    add_encode(255);
    add_encode(8'h80);
    add_finish();
    push_req(OP_NONE, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    add_encode(3);
    add_encode(3);
    add_encode(0);
    add_finish();
    add_encode(9);
    add_finish();
    add_load(255, 32'h0, 6'd0);
    add_encode(255);
    add_encode(0);
    add_finish();
    add_load(8'h41, 32'h0000_0001, 6'd33);
    add_encode(8'h41);
    add_finish();

    // random traffic in four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      phase_end = gen_count + 78;
      while (gen_count < phase_end) begin
        p = $urandom_range(99);
        if (p < 15) begin
          repeat ($urandom_range(1, 4)) add_load($urandom_range(255), $urandom, rand_len());
        end else if (p < 85) begin
          // one message: a run of encodes closed by a finish
          repeat ($urandom_range(2, 10)) begin
            pick_live(sym);
            add_encode(sym);
          end
          add_finish();
        end else begin
          case ($urandom_range(3))
            0: push_req(OP_NONE, $urandom_range(255), $urandom, LenW'($urandom));
            1: add_encode($urandom_range(255));
            2: add_finish();
            default: add_load($urandom_range(255), $urandom, 6'd0);
          endcase
        end
      end
      wait_idle();
    end

    // drain: let any stray result show up
    repeat (16) @(posedge clk_i);
    if (byte_exp_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, byte_exp_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pcbp_pkg.sv
rtl/pcbp_ram.sv
rtl/pcbp_front.sv
rtl/pcbp_queue.sv
rtl/pcbp_back.sv
rtl/prefix_code_bit_packer_core.sv
verif/prefix_code_bit_packer_core_tb.sv
